// File: sv/fat_chain_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// FAT chain block allocator - assertion macros
// Concurrent assertion wrappers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define FCBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fcba: invariant violated");

// same-cycle implication
`define FCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcba: implication violated");

// next-cycle implication
`define FCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcba: next-cycle implication violated");

`else

`define FCBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FCBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/fcba_pkg.sv
// ----------------------------------------------------------------------------
// FAT chain block allocator - package
// Field widths, action and status codes, default table depth.
// ----------------------------------------------------------------------------
package fcba_pkg;

    // default built table depth
    localparam int TABLE_ENTRIES_DEF = 256;

    // transaction field widths
    localparam int ACTION_W   = 3;
    localparam int BLK_IN_W   = 10;
    localparam int STATUS_W   = 2;
    localparam int BOUT_W     = 11;
    localparam int COUNT_W    = 10;
    localparam int CFG_W      = 11;

    // configuration register reset value and lower clamp
    localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = 11'd256;
    localparam logic [CFG_W-1:0] CFG_ENTRIES_MIN = 11'd2;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    // action codes
    localparam t_action ACT_FORMAT    = 3'd0;
    localparam t_action ACT_ALLOC     = 3'd1;
    localparam t_action ACT_FREE_CHN  = 3'd2;
    localparam t_action ACT_FREE_ONE  = 3'd3;
    localparam t_action ACT_EXTEND    = 3'd4;
    localparam t_action ACT_READ_LINK = 3'd5;

    // status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NO_FREE = 2'd1;
    localparam t_status ST_RANGE   = 2'd2;

    // "end / none" on the block output
    localparam logic signed [BOUT_W-1:0] BOUT_NONE = '1;

endpackage

// File: sv/fat_chain_block_allocator.sv
// ----------------------------------------------------------------------------
// FAT chain block allocator
// Link table in one synchronous RAM, free-list head and free count in flops.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; the input is ready again once the
// result has moved into the output register. Free-chain and extend walk the
// chain with one table read per cycle, capped at TABLE_ENTRIES blocks, and
// format writes one table entry per cycle over the effective entries_in_use.
// Format must be issued before any other action that reads the table;
// entries_in_use is clamped to 2..TABLE_ENTRIES and may only be written while
// the block is idle.
// ----------------------------------------------------------------------------
`include "fat_chain_block_allocator_defines.svh"

module fat_chain_block_allocator
    import fcba_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [ACTION_W-1:0]      i_action,
    input  logic [BLK_IN_W-1:0]      i_block_index,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [BOUT_W-1:0] o_block_out,
    output logic [COUNT_W-1:0]       o_free_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);       // block index bits
    localparam int EW = IW + 1;                      // entry bits, top bit = end mark
    localparam int NW = $clog2(TABLE_ENTRIES + 1);   // chain length bits
    localparam int CW = IW;                          // free count bits
    localparam int SW = NW + 1;                      // count sum bits

    localparam logic [EW-1:0]    END_MARK  = '1;
    localparam logic [NW-1:0]    LEN_MAX   = NW'(TABLE_ENTRIES);
    localparam logic [SW-1:0]    TOTAL_MAX = SW'(TABLE_ENTRIES - 1);
    localparam logic [CFG_W-1:0] CFG_MAX   = CFG_W'(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FMT  = 7'b0000010,
        S_WALK = 7'b0000100,
        S_POP  = 7'b0001000,
        S_LINK = 7'b0010000,
        S_RDL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // registers
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_entries;
    t_action               r_act, n_act;
    logic [IW-1:0]         r_blk, n_blk;
    logic [IW-1:0]         r_cur, n_cur;
    logic [NW-1:0]         r_len, n_len;
    logic [IW-1:0]         r_tail, n_tail;
    logic [IW-1:0]         r_cnt, n_cnt;
    logic [EW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_total, n_total;
    t_status               r_res_status, n_res_status;
    logic signed [BOUT_W-1:0] r_res_block, n_res_block;
    logic                  r_o_valid, n_o_valid;
    t_status               r_o_status, n_o_status;
    logic signed [BOUT_W-1:0] r_o_block, n_o_block;
    logic [CW-1:0]         r_o_count, n_o_count;

    // link table RAM ports
    logic [EW-1:0]         mem [TABLE_ENTRIES];
    logic [EW-1:0]         r_rdata;
    logic                  re, we;
    logic [IW-1:0]         ra, wa;
    logic [EW-1:0]         wd;

    // misc combinational
    logic [CFG_W-1:0]      n_eff;
    logic                  accept;
    logic                  needs_index;
    logic                  idx_err;
    logic                  head_empty;
    logic                  fmt_last;
    logic                  walk_done;
    logic [SW-1:0]         add_len;
    logic [SW-1:0]         add_sum;
    logic [CW-1:0]         total_added;

    // effective number of managed blocks
    always_comb begin
        n_eff = r_entries;
        if (r_entries < CFG_ENTRIES_MIN) begin
            n_eff = CFG_ENTRIES_MIN;
        end else if (r_entries > CFG_MAX) begin
            n_eff = CFG_MAX;
        end
    end

    assign accept      = i_in_valid && o_in_ready;
    assign needs_index = (i_action inside {ACT_FREE_CHN, ACT_FREE_ONE, ACT_EXTEND,
                                           ACT_READ_LINK});
    assign idx_err     = needs_index && ({1'b0, i_block_index} >= n_eff);
    assign head_empty  = r_head[EW-1];
    assign fmt_last    = (CFG_W'(r_cnt) == (n_eff - 1'b1));
    assign walk_done   = r_rdata[EW-1] || (r_len == LEN_MAX);

    // saturating count add (chain length, or one for a single push)
    assign add_len     = r_state[2] ? SW'(r_len) : SW'(1);
    assign add_sum     = SW'(r_total) + add_len;
    assign total_added = (add_sum > TOTAL_MAX) ? CW'(TOTAL_MAX) : CW'(add_sum);

    // link table RAM: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    // control and datapath next state
    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_blk        = r_blk;
        n_cur        = r_cur;
        n_len        = r_len;
        n_tail       = r_tail;
        n_cnt        = r_cnt;
        n_head       = r_head;
        n_total      = r_total;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_block    = r_o_block;
        n_o_count    = r_o_count;
        re           = 1'b0;
        ra           = '0;
        we           = 1'b0;
        wa           = '0;
        wd           = '0;

        // output register drains independently
        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act        = i_action;
                    n_blk        = i_block_index[IW-1:0];
                    n_cur        = i_block_index[IW-1:0];
                    n_len        = NW'(1);
                    n_cnt        = '0;
                    n_res_status = ST_OK;
                    n_res_block  = BOUT_NONE;
                    n_state      = S_OUT;
                    if (idx_err) begin
                        n_res_status = ST_RANGE;
                    end else begin
                        case (i_action)
                            ACT_FORMAT: begin
                                n_state = S_FMT;
                            end
                            ACT_ALLOC: begin
                                if (head_empty) begin
                                    n_res_status = ST_NO_FREE;
                                end else begin
                                    re      = 1'b1;
                                    ra      = r_head[IW-1:0];
                                    n_state = S_POP;
                                end
                            end
                            ACT_FREE_CHN: begin
                                re      = 1'b1;
                                ra      = i_block_index[IW-1:0];
                                n_state = S_WALK;
                            end
                            ACT_FREE_ONE: begin
                                // push one block on the free list
                                we      = 1'b1;
                                wa      = i_block_index[IW-1:0];
                                wd      = r_head;
                                n_head  = {1'b0, i_block_index[IW-1:0]};
                                n_total = total_added;
                            end
                            ACT_EXTEND: begin
                                if (head_empty) begin
                                    n_res_status = ST_NO_FREE;
                                end else begin
                                    re      = 1'b1;
                                    ra      = i_block_index[IW-1:0];
                                    n_state = S_WALK;
                                end
                            end
                            ACT_READ_LINK: begin
                                re      = 1'b1;
                                ra      = i_block_index[IW-1:0];
                                n_state = S_RDL;
                            end
                            default: begin
                                // unused actions answer ok with no change
                            end
                        endcase
                    end
                end
            end

            // format sweep: one entry written per cycle
            S_FMT: begin
                we    = 1'b1;
                wa    = r_cnt;
                wd    = ((r_cnt == '0) || fmt_last) ? END_MARK : {1'b0, r_cnt + 1'b1};
                n_cnt = r_cnt + 1'b1;
                if (fmt_last) begin
                    n_head  = EW'(1);
                    n_total = CW'(n_eff - 1'b1);
                    n_state = S_OUT;
                end
            end

            // chain walk: r_rdata holds link of r_cur
            S_WALK: begin
                if (walk_done) begin
                    n_tail = r_cur;
                    if (r_act == ACT_EXTEND) begin
                        re      = 1'b1;
                        ra      = r_head[IW-1:0];
                        n_state = S_POP;
                    end else begin
                        // splice chain in front of the free list
                        we      = 1'b1;
                        wa      = r_cur;
                        wd      = r_head;
                        n_head  = {1'b0, r_blk};
                        n_total = total_added;
                        n_state = S_OUT;
                    end
                end else begin
                    n_cur = r_rdata[IW-1:0];
                    n_len = r_len + 1'b1;
                    re    = 1'b1;
                    ra    = r_rdata[IW-1:0];
                end
            end

            // pop free head: r_rdata holds its link
            S_POP: begin
                we          = 1'b1;
                wa          = r_head[IW-1:0];
                wd          = END_MARK;
                n_head      = r_rdata;
                n_res_block = {{(BOUT_W-IW){1'b0}}, r_head[IW-1:0]};
                if (r_total != '0) begin
                    n_total = r_total - 1'b1;
                end
                n_state = (r_act == ACT_EXTEND) ? S_LINK : S_OUT;
            end

            // link old tail to the newly allocated block
            S_LINK: begin
                we      = 1'b1;
                wa      = r_tail;
                wd      = {1'b0, r_res_block[IW-1:0]};
                n_state = S_OUT;
            end

            S_RDL: begin
                if (!r_rdata[EW-1]) begin
                    n_res_block = {{(BOUT_W-IW){1'b0}}, r_rdata[IW-1:0]};
                end
                n_state = S_OUT;
            end

            // hand result to the output register once it has room
            S_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_block  = r_res_block;
                    n_o_count  = r_total;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= END_MARK;
            r_total   <= '0;
            r_entries <= CFG_ENTRIES_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_blk        <= n_blk;
        r_cur        <= n_cur;
        r_len        <= n_len;
        r_tail       <= n_tail;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_o_status   <= n_o_status;
        r_o_block    <= n_o_block;
        r_o_count    <= n_o_count;
    end

    // ports
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_block_out  = r_o_block;
    assign o_free_count = COUNT_W'(r_o_count);

    // assertions
    `FCBA_ASSERT_IMPL(a_no_rw_same_addr, i_clk, i_rst_n, re && we, ra != wa)
    `FCBA_ASSERT_ALWAYS(a_total_bound, i_clk, i_rst_n, SW'(r_total) <= TOTAL_MAX)
    `FCBA_ASSERT_NEXT(a_fmt_head, i_clk, i_rst_n, (r_state == S_FMT) && fmt_last, r_head == EW'(1))
    `FCBA_ASSERT_IMPL(a_err_none, i_clk, i_rst_n, r_o_valid && (r_o_status != ST_OK), r_o_block == BOUT_NONE)

endmodule

// File: tb/fat_chain_block_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT chain block allocator - testbench
// Drives link-table actions through the valid/ready input channel. A local
// copy of the link table, free-list head and free count predicts every reply,
// and each reply is checked field by field. Random idle bursts are applied on
// both channels outside the steady-stream test.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator_tb;
    import fcba_pkg::*;

    localparam int TBL         = TABLE_ENTRIES_DEF;
    localparam int END_LNK     = -1;
    localparam int STALL_LIMIT = 4000;

    // codes the block does not use; they must leave the table alone
    localparam t_action ACT_SPARE_6 = 3'd6;
    localparam t_action ACT_SPARE_7 = 3'd7;

    typedef struct {
        t_status                     status;
        logic signed [BOUT_W-1:0]    block_out;
        logic [COUNT_W-1:0]          free_count;
    } t_alloc_reply;

    // DUT inputs, all known from time zero
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic [ACTION_W-1:0]   in_action   = '0;
    logic [BLK_IN_W-1:0]   in_block    = '0;
    logic                  out_ready   = 1'b0;

    // DUT outputs
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic signed [BOUT_W-1:0] o_block_out;
    logic [COUNT_W-1:0]    o_free_count;

    // predicted allocator state
    int                    link_mem [TBL];
    int                    head_blk;
    int                    free_cnt;
    logic [CFG_W-1:0]      entries_reg;

    t_alloc_reply          pending_replies [$];
    int                    owned_heads [$];
    bit                    idle_on;
    int                    fail_count   = 0;
    int                    sent_count;
    int                    reply_count  = 0;
    int                    size_writes;
    int                    stall_left   = 0;
    int                    stuck_cycles = 0;

    fat_chain_block_allocator #(
        .TABLE_ENTRIES (TBL)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (in_action),
        .i_block_index (in_block),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_block_out   (o_block_out),
        .o_free_count  (o_free_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------------

    // effective block count after clamping the size register
    function automatic int blocks_managed();
        int n;
        n = int'(entries_reg);
        if (n < int'(CFG_ENTRIES_MIN)) n = int'(CFG_ENTRIES_MIN);
        if (n > TBL) n = TBL;
        return n;
    endfunction

    // follow links to the chain tail, capped at the table depth
    function automatic int chain_tail(input int b, output int len);
        len = 1;
        while (link_mem[b] != END_LNK && len < TBL) begin
            b = link_mem[b];
            len++;
        end
        return b;
    endfunction

    function automatic int pop_free_block();
        int b;
        b = head_blk;
        head_blk = link_mem[b];
        link_mem[b] = END_LNK;
        if (free_cnt > 0) free_cnt--;
        return b;
    endfunction

    function automatic void add_free(input int k);
        free_cnt = (free_cnt + k > TBL - 1) ? TBL - 1 : free_cnt + k;
    endfunction

    // update the local table for one action and return the reply it gives
    function automatic t_alloc_reply apply_to_links(input t_action act,
                                                    input logic [BLK_IN_W-1:0] blk_in);
        t_alloc_reply r;
        int n, blk, len, tail, nb, i;
        bit needs_index;
        n = blocks_managed();
        blk = int'(blk_in);
        r.status = ST_OK;
        r.block_out = BOUT_NONE;
        needs_index = (act >= ACT_FREE_CHN && act <= ACT_READ_LINK);
        if (needs_index && blk >= n) begin
            r.status = ST_RANGE;
        end else begin
            case (act)
                ACT_FORMAT: begin
                    link_mem[0] = END_LNK;
                    for (i = 1; i + 1 < n; i++) link_mem[i] = i + 1;
                    link_mem[n-1] = END_LNK;
                    head_blk = 1;
                    free_cnt = n - 1;
                end
                ACT_ALLOC: begin
                    if (head_blk == END_LNK) r.status = ST_NO_FREE;
                    else r.block_out = BOUT_W'(pop_free_block());
                end
                ACT_FREE_CHN: begin
                    tail = chain_tail(blk, len);
                    link_mem[tail] = head_blk;
                    head_blk = blk;
                    add_free(len);
                end
                ACT_FREE_ONE: begin
                    link_mem[blk] = head_blk;
                    head_blk = blk;
                    add_free(1);
                end
                ACT_EXTEND: begin
                    if (head_blk == END_LNK) begin
                        r.status = ST_NO_FREE;
                    end else begin
                        tail = chain_tail(blk, len);
                        nb = pop_free_block();
                        link_mem[tail] = nb;
                        r.block_out = BOUT_W'(nb);
                    end
                end
                ACT_READ_LINK: begin
                    if (link_mem[blk] != END_LNK) r.block_out = BOUT_W'(link_mem[blk]);
                end
                default: begin
                end
            endcase
        end
        r.free_count = COUNT_W'(free_cnt);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // present one action, wait for its transaction, queue its predicted reply
    task automatic send_action(input t_action act, input logic [BLK_IN_W-1:0] blk,
                               output t_alloc_reply reply);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_block  <= blk;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        reply = apply_to_links(act, blk);
        pending_replies.push_back(reply);
        sent_count++;
    endtask

    // drop valid and wait until every reply is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entries(input logic [CFG_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        entries_reg = value;
        size_writes++;
    endtask

    // receiver side: random stall bursts on out_ready while idling is enabled
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            out_ready  <= 1'b1;
        end
    end

    // reply checker and watchdog
    always @(posedge clk) begin
        t_alloc_reply want;
        if (!rst_n) begin
            stuck_cycles = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                reply_count++;
                if (pending_replies.size() == 0) begin
                    $error("unexpected reply: status %0d block_out %0d free_count %0d",
                           o_status, o_block_out, o_free_count);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        fail_count++;
                    end
                    if (o_block_out !== want.block_out) begin
                        $error("block_out mismatch: expected %0d, actual %0d",
                               want.block_out, o_block_out);
                        fail_count++;
                    end
                    if (o_free_count !== want.free_count) begin
                        $error("free_count mismatch: expected %0d, actual %0d",
                               want.free_count, o_free_count);
                        fail_count++;
                    end
                end
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // before any format: only actions that leave the table unread
    task automatic test_unformatted();
        t_alloc_reply r;
        send_action(ACT_ALLOC, '0, r);               // empty list
        send_action(ACT_EXTEND, 10'd5, r);           // empty list
        send_action(ACT_EXTEND, 10'd300, r);         // range wins over empty
        send_action(ACT_READ_LINK, 10'd256, r);
        send_action(ACT_FREE_CHN, 10'd1023, r);
        send_action(ACT_FREE_ONE, 10'd512, r);
        send_action(ACT_SPARE_6, '0, r);
        send_action(ACT_SPARE_7, 10'd1023, r);
    endtask

    // every action on an 8-block table
    task automatic test_small_table();
        t_alloc_reply r;
        write_entries(11'd8);
        send_action(ACT_FORMAT, 10'd1023, r);
        send_action(ACT_ALLOC, '0, r);
        send_action(ACT_ALLOC, 10'd1023, r);
        send_action(ACT_EXTEND, 10'd1, r);
        send_action(ACT_READ_LINK, 10'd1, r);
        send_action(ACT_READ_LINK, 10'd3, r);
        send_action(ACT_READ_LINK, 10'd0, r);        // root stays an end mark
        send_action(ACT_EXTEND, 10'd1, r);           // walk two links
        send_action(ACT_FREE_ONE, 10'd2, r);
        send_action(ACT_FREE_CHN, 10'd1, r);
        send_action(ACT_READ_LINK, 10'd4, r);
        send_action(ACT_EXTEND, 10'd8, r);           // first index out of range
        send_action(ACT_READ_LINK, 10'd7, r);
        send_action(ACT_ALLOC, '0, r);
    endtask

    // size register below the floor acts as two blocks
    task automatic test_clamp_low();
        t_alloc_reply r;
        write_entries(11'd0);
        send_action(ACT_FORMAT, '0, r);
        send_action(ACT_ALLOC, '0, r);
        send_action(ACT_ALLOC, '0, r);
        send_action(ACT_EXTEND, 10'd0, r);
        send_action(ACT_READ_LINK, 10'd1, r);
        send_action(ACT_READ_LINK, 10'd2, r);
        send_action(ACT_FREE_ONE, 10'd1, r);
        write_entries(11'd1);
        send_action(ACT_FORMAT, '0, r);
        send_action(ACT_EXTEND, 10'd0, r);
        send_action(ACT_READ_LINK, 10'd0, r);
    endtask

    // count saturation at both ends and a self-linked chain
    task automatic test_count_limits();
        t_alloc_reply r;
        write_entries(11'd2047);                     // clamps to full depth
        send_action(ACT_FORMAT, '0, r);
        send_action(ACT_FREE_ONE, 10'd0, r);         // count pinned at the top
        send_action(ACT_READ_LINK, 10'd0, r);
        // drain: one more block on the list than the count admits
        repeat (TBL + 1) send_action(ACT_ALLOC, '0, r);
        send_action(ACT_FREE_ONE, 10'd5, r);
        send_action(ACT_FREE_ONE, 10'd5, r);         // block 5 now links to itself
        send_action(ACT_FREE_CHN, 10'd5, r);         // walk stops at the depth cap
        send_action(ACT_EXTEND, 10'd3, r);
        send_action(ACT_READ_LINK, 10'd5, r);
        send_action(ACT_FORMAT, '0, r);
    endtask

    // mostly well-formed chain traffic on owned chains, with some noise
    task automatic run_random_mix(input int items);
        t_alloc_reply r;
        t_action act;
        int n, pick, j, k, blk;
        repeat (items) begin
            n = blocks_managed();
            pick = $urandom_range(0, 99);
            act = ACT_READ_LINK;
            blk = 0;
            if (pick < 10) begin
                act = t_action'($urandom_range(0, 7));
                blk = $urandom_range(0, 1) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, n - 1);
                if (act == ACT_FORMAT) owned_heads.delete();
            end else if (pick < 12) begin
                act = ACT_FORMAT;
                owned_heads.delete();
            end else if (owned_heads.size() == 0 || pick < 30) begin
                act = ACT_ALLOC;
                blk = $urandom_range(0, 1023);
            end else begin
                j = $urandom_range(0, owned_heads.size() - 1);
                blk = owned_heads[j];
                if (pick < 55) begin
                    act = ACT_EXTEND;
                end else if (pick < 70 || owned_heads.size() > 12) begin
                    act = ACT_FREE_CHN;
                    owned_heads.delete(j);
                end else if (pick < 78 && link_mem[blk] == END_LNK) begin
                    act = ACT_FREE_ONE;
                    owned_heads.delete(j);
                end else begin
                    // read somewhere along the chain
                    k = $urandom_range(0, 6);
                    while (k > 0 && link_mem[blk] != END_LNK) begin
                        blk = link_mem[blk];
                        k--;
                    end
                end
            end
            send_action(act, BLK_IN_W'(blk), r);
            if (act == ACT_ALLOC && r.status == ST_OK)
                owned_heads.push_back(int'(r.block_out));
        end
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] sizes [7];
        t_alloc_reply r;
        int p;
        sizes = '{11'd4, 11'd257, 11'd16, 11'd37, 11'd3, 11'd256, 11'd0};
        sizes[6] = CFG_W'($urandom_range(5, 200));
        for (p = 0; p < 7; p++) begin
            write_entries(sizes[p]);
            send_action(ACT_FORMAT, '0, r);
            owned_heads.delete();
            run_random_mix(90);
        end
    endtask

    // back-to-back traffic, no idling on either side
    task automatic test_steady_stream();
        t_alloc_reply r;
        idle_on = 1'b0;
        write_entries(11'd1024);
        send_action(ACT_FORMAT, '0, r);
        owned_heads.delete();
        run_random_mix(120);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (link_mem[i]) link_mem[i] = 0;
        head_blk     = END_LNK;
        free_cnt     = 0;
        entries_reg  = CFG_ENTRIES_RST;
        idle_on      = 1'b1;
        sent_count   = 0;
        size_writes  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unformatted();
        test_small_table();
        test_clamp_low();
        test_count_limits();
        test_random_phases();
        test_steady_stream();

        settle();
        repeat (20) @(posedge clk);
        $display("Applied %0d actions under %0d table-size settings; %0d replies checked.",
                 sent_count, size_writes, reply_count);
        $display("Chain walks, list exhaustion, count saturation and range errors exercised.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
